### rtl/tlcdm_pkg.sv
// Shared types and constants for the two-layer CDM chip decoder.
package tlcdm_pkg;

	// Chips per frame and the frame index width
	localparam int unsigned FRAME_CHIPS = 16;
	localparam int unsigned IDX_W       = 4;

	// Ternary codewords as position masks, bit i for chip i
	localparam logic [FRAME_CHIPS-1:0] CODE_A_POS = 16'h2841;
	localparam logic [FRAME_CHIPS-1:0] CODE_A_NEG = 16'h8214;
	localparam logic [FRAME_CHIPS-1:0] CODE_B_POS = 16'h1482;
	localparam logic [FRAME_CHIPS-1:0] CODE_B_NEG = 16'h4128;

	// Intensity estimator: count restart value and register alignment
	localparam logic [31:0] COUNT_INIT = 32'd32;
	localparam int unsigned INIT_SHIFT = 7;

	// Decoder sequencer states
	typedef enum logic [2:0] {
		S_FILL,
		S_CORR,
		S_MAG,
		S_DIV,
		S_FIN
	} dec_state_t;

endpackage

### rtl/two_layer_cdm_chip_decoder.sv
// Two-layer CDM chip decoder: chip memory, correlation pass, divider and byte packing.
//
// Chip samples are written one per cycle into a 16-entry chip memory while the block
// is filling a frame. The 16th sample starts the frame decode, during which no sample
// is taken: a correlation pass reads the memory one chip per cycle, a magnitude step
// updates the intensity estimate, a bit-serial divider forms sum/count, and a finish
// step builds the nibble. Every second frame gives one data byte; the finish step
// waits only while the previous byte is still held in the output register.
// The configuration word restarts the intensity estimate and is taken while filling.
module two_layer_cdm_chip_decoder #(
	parameter int unsigned SAMPLE_BITS = 12
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [24:0]            initial_intensity,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [SAMPLE_BITS-1:0] sample,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [7:0]             data_byte
);
	import tlcdm_pkg::*;

	localparam int unsigned CORR_W = SAMPLE_BITS + 4;

	dec_state_t state_q, state_d;

	logic [IDX_W-1:0]       fill_idx_q;
	logic [4:0]             cnt_q;
	logic [SAMPLE_BITS-1:0] chip_mem [FRAME_CHIPS];
	logic [SAMPLE_BITS-1:0] rd_data_s1;
	logic [IDX_W-1:0]       rd_idx_s1;
	logic                   rd_valid_s1;
	logic signed [CORR_W-1:0] corr_a_q, corr_b_q;
	logic [31:0]            sum_q, count_q;
	logic [31:0]            quo_q, rem_q;
	logic                   ba1_q, bb1_q;
	logic [3:0]             held_nib_q;
	logic                   nib_held_q;
	logic                   out_valid_q;
	logic [7:0]             out_byte_q;

	logic                   in_acc, cfg_acc, out_free, fin_go, byte_load;
	logic [CORR_W-1:0]      chip_ext, mag_a, mag_b;
	logic [31:0]            sum_next;
	logic [32:0]            rem_sh;
	logic                   rem_ge;
	logic [31:0]            ya_ext, yb_ext, lvl4, ya2, yb2;
	logic [3:0]             nibble;

	assign in_acc    = in_valid && in_ready;
	assign cfg_acc   = cfg_valid && cfg_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign byte_load = (state_q == S_FIN) && fin_go && nib_held_q;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_FILL: if (in_acc && (fill_idx_q == IDX_W'(FRAME_CHIPS - 1))) state_d = S_CORR;
			S_CORR: if (cnt_q == 5'(FRAME_CHIPS)) state_d = S_MAG;
			S_MAG:  state_d = S_DIV;
			S_DIV:  if (cnt_q == 5'd31) state_d = S_FIN;
			S_FIN:  if (fin_go) state_d = S_FILL;
			default: state_d = S_FILL;
		endcase
	end

	// Handshake outputs
	always_comb begin
		in_ready  = 1'b0;
		cfg_ready = 1'b0;
		fin_go    = 1'b0;
		case (state_q)
			S_FILL: begin
				in_ready  = 1'b1;
				cfg_ready = 1'b1;
			end
			S_FIN:   fin_go = !nib_held_q || out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_FILL;
		end else begin
			state_q <= state_d;
		end
	end

	// Chip memory: sample writes, one registered read a cycle
	always_ff @(posedge clk) begin
		if (in_acc) begin
			chip_mem[fill_idx_q] <= sample;
		end
		rd_data_s1 <= chip_mem[cnt_q[IDX_W-1:0]];
		rd_idx_s1  <= cnt_q[IDX_W-1:0];
	end

	// Fill index and shared pass counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_idx_q  <= '0;
			cnt_q       <= '0;
			rd_valid_s1 <= 1'b0;
		end else begin
			rd_valid_s1 <= (state_q == S_CORR) && !cnt_q[4];
			if (in_acc) begin
				fill_idx_q <= fill_idx_q + 1'b1;
			end
			case (state_q)
				S_CORR, S_DIV: cnt_q <= cnt_q + 1'b1;
				default:       cnt_q <= '0;
			endcase
		end
	end

	// Correlation accumulate
	assign chip_ext = CORR_W'(rd_data_s1);

	always_ff @(posedge clk) begin
		if (state_q == S_FILL) begin
			corr_a_q <= '0;
			corr_b_q <= '0;
		end else if ((state_q == S_CORR) && rd_valid_s1) begin
			if (CODE_A_POS[rd_idx_s1]) corr_a_q <= corr_a_q + signed'(chip_ext);
			else if (CODE_A_NEG[rd_idx_s1]) corr_a_q <= corr_a_q - signed'(chip_ext);
			if (CODE_B_POS[rd_idx_s1]) corr_b_q <= corr_b_q + signed'(chip_ext);
			else if (CODE_B_NEG[rd_idx_s1]) corr_b_q <= corr_b_q - signed'(chip_ext);
		end
	end

	// Magnitudes and intensity sum update
	assign mag_a    = corr_a_q[CORR_W-1] ? CORR_W'(-corr_a_q) : CORR_W'(corr_a_q);
	assign mag_b    = corr_b_q[CORR_W-1] ? CORR_W'(-corr_b_q) : CORR_W'(corr_b_q);
	assign sum_next = sum_q + 32'(mag_a) + 32'(mag_b);

	// Restoring divider step, one quotient bit a cycle
	assign rem_sh = {rem_q, quo_q[31]};
	assign rem_ge = rem_sh >= {1'b0, count_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q   <= '0;
			count_q <= COUNT_INIT;
		end else if (cfg_acc) begin
			sum_q   <= {initial_intensity, INIT_SHIFT'(0)};
			count_q <= COUNT_INIT;
		end else if (state_q == S_MAG) begin
			sum_q   <= sum_next;
			count_q <= count_q + 32'd2;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_MAG) begin
			quo_q <= sum_next;
			rem_q <= '0;
			ba1_q <= (corr_a_q == '0) || corr_a_q[CORR_W-1];
			bb1_q <= (corr_b_q == '0) || corr_b_q[CORR_W-1];
		end else if (state_q == S_DIV) begin
			quo_q <= {quo_q[30:0], rem_ge};
			rem_q <= rem_ge ? 32'(rem_sh - {1'b0, count_q}) : rem_sh[31:0];
		end
	end

	// Layer 2: remove four times the level, sign picks the bit
	assign lvl4   = {quo_q[31:2], 2'b00};
	assign ya_ext = 32'(corr_a_q);
	assign yb_ext = 32'(corr_b_q);
	assign ya2    = ba1_q ? ya_ext + lvl4 : ya_ext - lvl4;
	assign yb2    = bb1_q ? yb_ext + lvl4 : yb_ext - lvl4;
	assign nibble = {~yb2[31], ~ya2[31], bb1_q, ba1_q};

	// Nibble pairing and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nib_held_q  <= 1'b0;
			held_nib_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// a new word may take the slot in the cycle the old one leaves
			if (byte_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if ((state_q == S_FIN) && fin_go) begin
				if (!nib_held_q) begin
					held_nib_q <= nibble;
					nib_held_q <= 1'b1;
				end else begin
					nib_held_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (byte_load) begin
			out_byte_q <= {nibble, held_nib_q};
		end
	end

	assign out_valid = out_valid_q;
	assign data_byte = out_byte_q;

endmodule

### rtl/tlcdm_checker.sv
// Port-level checker for the two-layer CDM chip decoder, with its bind.
module tlcdm_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] data_byte
);
	logic [3:0] chip_cnt_q;
	logic       frame_odd_q;
	logic [1:0] due_q;
	logic       in_acc, out_acc, frame_end, pair_end;

	assign in_acc    = in_valid && in_ready;
	assign out_acc   = out_valid && out_ready;
	assign frame_end = in_acc && (chip_cnt_q == 4'hF);
	assign pair_end  = frame_end && frame_odd_q;

	// Shadow count of chips, frames and bytes owed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chip_cnt_q  <= '0;
			frame_odd_q <= 1'b0;
			due_q       <= '0;
		end else begin
			if (in_acc) chip_cnt_q <= chip_cnt_q + 1'b1;
			if (frame_end) frame_odd_q <= !frame_odd_q;
			if (pair_end && !out_acc) due_q <= due_q + 1'b1;
			else if (!pair_end && out_acc) due_q <= due_q - 1'b1;
		end
	end

	// A stalled word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(data_byte))
		else $error("output word changed while stalled");

	// The frame-completing chip starts a decode that blocks input
	a_decode_block: assert property (@(posedge clk) disable iff (!arst_n)
		frame_end |=> !in_ready)
		else $error("input taken during frame decode");

	// Input only stops right after a frame-completing chip
	a_stop_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(in_ready) |-> $past(in_valid && in_ready) && (chip_cnt_q == 4'h0))
		else $error("input stalled outside a frame decode");

	// Every output word is owed by a completed frame pair
	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (due_q != 2'd0))
		else $error("output word without a completed frame pair");

endmodule

bind two_layer_cdm_chip_decoder tlcdm_checker u_tlcdm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.data_byte (data_byte)
);
